@@ rtl/core/lsct_pkg.sv @@
// Package for the LCD scanline timer: register indexes, limits and the
// structs passed between the configuration, step and top-level modules.
// No dependencies.
package lsct_pkg;

   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned PeriodWidth   = 10;
   localparam int unsigned LineWidth     = 8;
   localparam int unsigned FrameWidth    = 32;
   localparam int unsigned DotsWidth     = 8;
   localparam int unsigned RspDataWidth  = 48;

   typedef logic [CsrIndexWidth-1:0] csr_index_type;

   localparam csr_index_type REG_DISPLAY_ENABLE     = 2'd0;
   localparam csr_index_type REG_COMPARE_LINE       = 2'd1;
   localparam csr_index_type REG_COMPARE_IRQ_SELECT = 2'd2;
   localparam csr_index_type REG_LINE_PERIOD        = 2'd3;

   localparam logic [PeriodWidth-1:0] PERIOD_RESET = 10'd456;
   localparam logic [PeriodWidth-1:0] ACC_MAX      = 10'd1023;
   localparam logic [LineWidth-1:0]   LAST_LINE    = 8'd153;
   localparam logic [LineWidth-1:0]   VBLANK_LINE  = 8'd144;

   typedef struct packed {
      logic                   display_enable;
      logic [LineWidth-1:0]   compare_line;
      logic                   compare_irq_select;
      logic [PeriodWidth-1:0] line_period;
   } cfg_type;

   typedef struct packed {
      logic [PeriodWidth-1:0] dot_accumulator;
      logic [LineWidth-1:0]   line_counter;
      logic [FrameWidth-1:0]  frames_done;
      logic                   match_flag;
   } state_type;

   typedef struct packed {
      logic vblank_irq;
      logic stat_irq;
      logic line_advanced;
   } pulse_type;

endpackage

@@ rtl/core/lsct_csr.sv @@
// Configuration registers of the LCD scanline timer.
// Depends on lsct_pkg.
module lsct_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  lsct_pkg::csr_index_type                csr_index,
   input  logic [lsct_pkg::PeriodWidth-1:0]       csr_data,
   output lsct_pkg::cfg_type                      cfg
);

   lsct_pkg::cfg_type cfg_ff;
   lsct_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            lsct_pkg::REG_DISPLAY_ENABLE: begin
               cfg_in.display_enable = csr_data[0];
            end
            lsct_pkg::REG_COMPARE_LINE: begin
               cfg_in.compare_line = csr_data[lsct_pkg::LineWidth-1:0];
            end
            lsct_pkg::REG_COMPARE_IRQ_SELECT: begin
               cfg_in.compare_irq_select = csr_data[0];
            end
            lsct_pkg::REG_LINE_PERIOD: begin
               cfg_in.line_period = csr_data;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.display_enable     <= 1'b0;
         cfg_ff.compare_line       <= '0;
         cfg_ff.compare_irq_select <= 1'b0;
         cfg_ff.line_period        <= lsct_pkg::PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/core/lsct_step.sv @@
// Next-state logic for one tick of the LCD scanline timer: frame wrap,
// dot accumulation, line advance, match flag and interrupt pulses.
// Depends on lsct_pkg.
module lsct_step (
   input  lsct_pkg::cfg_type                  cfg,
   input  lsct_pkg::state_type                state_cur,
   input  logic [lsct_pkg::DotsWidth-1:0]     dots,
   output lsct_pkg::state_type                state_nxt,
   output lsct_pkg::pulse_type                pulse
);

   logic                             wrap;
   logic [lsct_pkg::LineWidth-1:0]   line_base;
   logic [lsct_pkg::LineWidth-1:0]   line_inc;
   logic [lsct_pkg::PeriodWidth:0]   sum;
   logic [lsct_pkg::PeriodWidth:0]   sum_left;
   logic                             advance;
   logic                             match_nxt;

   always_comb begin
      wrap      = (state_cur.line_counter == lsct_pkg::LAST_LINE);
      line_base = wrap ? '0 : state_cur.line_counter;
      line_inc  = line_base + 8'd1;
      sum       = {1'b0, state_cur.dot_accumulator}
                  + {{(lsct_pkg::PeriodWidth + 1 - lsct_pkg::DotsWidth){1'b0}}, dots};
      advance   = (sum >= {1'b0, cfg.line_period});
      sum_left  = advance ? (sum - {1'b0, cfg.line_period}) : sum;
      match_nxt = advance ? (line_inc == cfg.compare_line) : state_cur.match_flag;

      state_nxt = state_cur;
      pulse     = '0;
      if (cfg.display_enable) begin
         state_nxt.frames_done     = state_cur.frames_done + {31'd0, wrap};
         state_nxt.line_counter    = advance ? line_inc : line_base;
         state_nxt.match_flag      = match_nxt;
         state_nxt.dot_accumulator = sum_left[lsct_pkg::PeriodWidth]
                                     ? lsct_pkg::ACC_MAX
                                     : sum_left[lsct_pkg::PeriodWidth-1:0];
         pulse.line_advanced       = advance;
         pulse.vblank_irq          = advance && (line_inc == lsct_pkg::VBLANK_LINE);
         pulse.stat_irq            = advance && match_nxt && cfg.compare_irq_select;
      end
   end

endmodule

@@ rtl/core/lcd_scanline_timer_core.sv @@
// Top level of the LCD scanline timer: request register, timer state,
// response register. Depends on lsct_pkg, lsct_csr and lsct_step.
//
// Each request is one tick carrying the dots elapsed since the last tick and
// yields exactly one response with the line counter, match flag, interrupt
// pulses and frame count after that tick. A request passes through an input
// register, the timer update is computed from it combinationally and stored with
// the response in an output register when the response side is free, so one
// request is accepted every cycle while the response side keeps up. Configuration
// writes take effect on the next cycle and are expected only while idle.
module lcd_scanline_timer_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // Fields from bit 0: dots_elapsed[7:0].
   input  logic [lsct_pkg::DotsWidth-1:0]       req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // Fields from bit 0: current_line[7:0], coincidence, vblank_irq, stat_irq,
   // line_advanced, frame_count[31:0], zero padding[3:0].
   output logic [lsct_pkg::RspDataWidth-1:0]    rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  lsct_pkg::csr_index_type              csr_index,
   input  logic [lsct_pkg::PeriodWidth-1:0]     csr_data
);

   lsct_pkg::cfg_type                   cfg;
   lsct_pkg::state_type                 state_ff;
   lsct_pkg::state_type                 state_in;
   lsct_pkg::pulse_type                 pulse;
   logic                                req_valid_ff;
   logic [lsct_pkg::DotsWidth-1:0]      req_dots_ff;
   logic                                rsp_valid_ff;
   logic [lsct_pkg::RspDataWidth-1:0]   rsp_data_ff;
   logic                                rsp_open;
   logic                                fire;

   lsct_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lsct_step u_step (
      .cfg       (cfg),
      .state_cur (state_ff),
      .dots      (req_dots_ff),
      .state_nxt (state_in),
      .pulse     (pulse)
   );

   assign rsp_open   = !rsp_valid_ff || rsp_tready;
   assign fire       = req_valid_ff && rsp_open;
   assign req_tready = !req_valid_ff || rsp_open;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_dots_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            state_ff <= state_in;
         end
         if (rsp_open) begin
            rsp_valid_ff <= req_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= {4'd0,
                         state_in.frames_done,
                         pulse.line_advanced,
                         pulse.stat_irq,
                         pulse.vblank_irq,
                         state_in.match_flag,
                         state_in.line_counter};
      end
   end

endmodule

@@ test/lcd_scanline_timer_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench for lcd_scanline_timer_core. It sends dot ticks and writes the
// registers between phases, and checks every response against its own scanline
// model. Depends on lsct_pkg and the RTL of lcd_scanline_timer_core.
module lcd_scanline_timer_core_tb;

   typedef enum logic [1:0] {ACT_TICK, ACT_CSR, ACT_DRAIN} action_kind_type;

   typedef struct {
      action_kind_type                  kind;
      logic [lsct_pkg::DotsWidth-1:0]   dots;
      lsct_pkg::csr_index_type          index;
      logic [lsct_pkg::PeriodWidth-1:0] value;
   } scan_action_type;

   typedef struct packed {
      logic [lsct_pkg::LineWidth-1:0]  current_line;
      logic                            coincidence;
      logic                            vblank_irq;
      logic                            stat_irq;
      logic                            line_advanced;
      logic [lsct_pkg::FrameWidth-1:0] frame_count;
   } line_status_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [lsct_pkg::DotsWidth-1:0]    req_tdata = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b1;
   logic [lsct_pkg::RspDataWidth-1:0] rsp_tdata;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   lsct_pkg::csr_index_type           csr_index = lsct_pkg::REG_DISPLAY_ENABLE;
   logic [lsct_pkg::PeriodWidth-1:0]  csr_data = '0;

   scan_action_type stimulus_q[$];
   line_status_type expected_status_q[$];
   scan_action_type head;
   line_status_type want;
   line_status_type got;

   lsct_pkg::cfg_type                lcd_cfg;
   logic [lsct_pkg::PeriodWidth-1:0] dot_acc;
   logic [lsct_pkg::LineWidth-1:0]   line_now;
   logic [lsct_pkg::FrameWidth-1:0]  frames_now;
   logic                             match_now;

   int   errors = 0;
   int   settle_cycles = 0;
   int   gap_left = 0;
   int   stall_left = 0;
   logic calm_phase = 1'b0;

   lcd_scanline_timer_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   function automatic line_status_type advance_scanline(
      input logic [lsct_pkg::DotsWidth-1:0] dots);
      line_status_type                r;
      logic [lsct_pkg::PeriodWidth:0] sum;
      r = '0;
      if (lcd_cfg.display_enable) begin
         if (line_now == lsct_pkg::LAST_LINE) begin
            frames_now = frames_now + 32'd1;
            line_now = '0;
         end
         sum = {1'b0, dot_acc} + {3'd0, dots};
         if (sum >= {1'b0, lcd_cfg.line_period}) begin
            sum = sum - {1'b0, lcd_cfg.line_period};
            line_now = line_now + 8'd1;
            r.line_advanced = 1'b1;
            r.vblank_irq = (line_now == lsct_pkg::VBLANK_LINE);
            match_now = (line_now == lcd_cfg.compare_line);
            r.stat_irq = lcd_cfg.compare_irq_select && match_now;
         end
         dot_acc = (sum > {1'b0, lsct_pkg::ACC_MAX}) ? lsct_pkg::ACC_MAX
                                                      : sum[lsct_pkg::PeriodWidth-1:0];
      end
      r.current_line = line_now;
      r.coincidence = match_now;
      r.frame_count = frames_now;
      return r;
   endfunction

   task automatic check_field(input string name, input longint exp_val, input longint act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         errors++;
      end
   endtask

   task automatic push_tick(input int dots);
      scan_action_type a;
      a.kind = ACT_TICK;
      a.dots = dots[lsct_pkg::DotsWidth-1:0];
      a.index = lsct_pkg::REG_DISPLAY_ENABLE;
      a.value = '0;
      stimulus_q.push_back(a);
   endtask

   task automatic push_csr(input lsct_pkg::csr_index_type index, input int value);
      scan_action_type a;
      a.kind = ACT_CSR;
      a.dots = '0;
      a.index = index;
      a.value = value[lsct_pkg::PeriodWidth-1:0];
      stimulus_q.push_back(a);
   endtask

   task automatic push_drain();
      scan_action_type a;
      a.kind = ACT_DRAIN;
      a.dots = '0;
      a.index = lsct_pkg::REG_DISPLAY_ENABLE;
      a.value = '0;
      stimulus_q.push_back(a);
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("FAIL");
      $finish;
   end

   // Request driver for the tick channel and the register channel.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_valid <= 1'b0;
         gap_left <= 0;
         calm_phase <= 1'b0;
      end else begin
         calm_phase <= (stimulus_q.size() < 60);
         if ((req_tvalid && !req_tready) || (csr_valid && !csr_ready)) begin
         end else if (gap_left != 0) begin
            req_tvalid <= 1'b0;
            csr_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (stimulus_q.size() == 0) begin
            req_tvalid <= 1'b0;
            csr_valid <= 1'b0;
         end else begin
            head = stimulus_q[0];
            case (head.kind)
               ACT_TICK: begin
                  csr_valid <= 1'b0;
                  if (!calm_phase && $urandom_range(0, 6) == 0) begin
                     req_tvalid <= 1'b0;
                     gap_left <= $urandom_range(0, 8);
                  end else begin
                     req_tvalid <= 1'b1;
                     req_tdata <= head.dots;
                     void'(stimulus_q.pop_front());
                  end
               end
               ACT_CSR: begin
                  req_tvalid <= 1'b0;
                  if (!req_tvalid && !csr_valid && settle_cycles >= 4) begin
                     csr_valid <= 1'b1;
                     csr_index <= head.index;
                     csr_data <= head.value;
                     void'(stimulus_q.pop_front());
                  end else begin
                     csr_valid <= 1'b0;
                  end
               end
               default: begin
                  req_tvalid <= 1'b0;
                  csr_valid <= 1'b0;
                  if (!req_tvalid && !csr_valid && settle_cycles >= 4) begin
                     void'(stimulus_q.pop_front());
                  end
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!reset && !calm_phase && $urandom_range(0, 6) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predicts on accepted requests and register writes, checks responses.
   always @(posedge clock) begin
      if (reset) begin
         settle_cycles <= 0;
         lcd_cfg.display_enable = 1'b0;
         lcd_cfg.compare_line = '0;
         lcd_cfg.compare_irq_select = 1'b0;
         lcd_cfg.line_period = lsct_pkg::PERIOD_RESET;
         dot_acc = '0;
         line_now = '0;
         frames_now = '0;
         match_now = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_status_q.size() == 0) begin
               $error("response with no request waiting: %h", rsp_tdata);
               errors++;
            end else begin
               want = expected_status_q.pop_front();
               check_field("current_line", want.current_line, rsp_tdata[7:0]);
               check_field("coincidence", want.coincidence, rsp_tdata[8]);
               check_field("vblank_irq", want.vblank_irq, rsp_tdata[9]);
               check_field("stat_irq", want.stat_irq, rsp_tdata[10]);
               check_field("line_advanced", want.line_advanced, rsp_tdata[11]);
               check_field("frame_count", want.frame_count, rsp_tdata[43:12]);
            end
         end
         if (req_tvalid && req_tready) begin
            got = advance_scanline(req_tdata);
            expected_status_q.push_back(got);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lsct_pkg::REG_DISPLAY_ENABLE:
                  lcd_cfg.display_enable = csr_data[0];
               lsct_pkg::REG_COMPARE_LINE:
                  lcd_cfg.compare_line = csr_data[lsct_pkg::LineWidth-1:0];
               lsct_pkg::REG_COMPARE_IRQ_SELECT:
                  lcd_cfg.compare_irq_select = csr_data[0];
               default:
                  lcd_cfg.line_period = csr_data;
            endcase
         end
         if (expected_status_q.size() == 0 && !req_tvalid && !csr_valid) begin
            settle_cycles <= settle_cycles + 1;
         end else begin
            settle_cycles <= 0;
         end
      end
   end

   initial begin
      int n_ticks;
      int phase_len;
      int pick;
      bit first_phase;

      // Disabled display: ticks must leave everything untouched.
      push_tick(0);
      push_tick(255);
      // Shortest period with a heavy backlog drives the accumulator into saturation.
      push_csr(lsct_pkg::REG_LINE_PERIOD, 1);
      push_csr(lsct_pkg::REG_COMPARE_LINE, 255);
      push_csr(lsct_pkg::REG_COMPARE_IRQ_SELECT, 1);
      push_csr(lsct_pkg::REG_DISPLAY_ENABLE, 1);
      push_tick(0);
      repeat (5) push_tick(255);
      repeat (2) push_tick(0);
      push_csr(lsct_pkg::REG_LINE_PERIOD, 1023);
      repeat (4) push_tick(255);
      // A new compare line only shows in the flag after the next line advance.
      push_csr(lsct_pkg::REG_COMPARE_LINE, 0);
      push_tick(1);
      push_csr(lsct_pkg::REG_DISPLAY_ENABLE, 0);
      push_tick(128);
      push_csr(lsct_pkg::REG_LINE_PERIOD, 456);
      push_csr(lsct_pkg::REG_DISPLAY_ENABLE, 1);
      push_tick(200);
      push_tick(255);
      push_tick(1);
      push_tick(0);

      n_ticks = 0;
      first_phase = 1'b1;
      while (n_ticks < 500) begin
         if (first_phase || $urandom_range(0, 2) == 0) begin
            push_csr(lsct_pkg::REG_DISPLAY_ENABLE, ($urandom_range(0, 7) != 0));
         end
         if (first_phase || $urandom_range(0, 1) == 0) begin
            push_csr(lsct_pkg::REG_COMPARE_LINE, ($urandom_range(0, 5) == 0) ?
                     $urandom_range(0, 255) : $urandom_range(0, 153));
         end
         if (first_phase || $urandom_range(0, 1) == 0) begin
            push_csr(lsct_pkg::REG_COMPARE_IRQ_SELECT, $urandom_range(0, 1));
         end
         if (first_phase || $urandom_range(0, 1) == 0) begin
            pick = $urandom_range(0, 7);
            case (pick)
               0:       push_csr(lsct_pkg::REG_LINE_PERIOD, 1);
               1:       push_csr(lsct_pkg::REG_LINE_PERIOD, 1023);
               2:       push_csr(lsct_pkg::REG_LINE_PERIOD, 456);
               3:       push_csr(lsct_pkg::REG_LINE_PERIOD, $urandom_range(1, 1023));
               default: push_csr(lsct_pkg::REG_LINE_PERIOD, $urandom_range(1, 160));
            endcase
         end
         first_phase = 1'b0;
         phase_len = $urandom_range(20, 80);
         repeat (phase_len) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) push_tick(0);
            else if (pick == 1) push_tick(255);
            else push_tick($urandom_range(0, 255));
            if ($urandom_range(0, 39) == 0) push_drain();
            n_ticks++;
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (stimulus_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      while (settle_cycles < 4) @(posedge clock);
      repeat (4) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/lsct_pkg.sv
rtl/core/lsct_csr.sv
rtl/core/lsct_step.sv
rtl/core/lcd_scanline_timer_core.sv
test/lcd_scanline_timer_core_tb.sv
